// File: sv/dwfs_pkg.sv
package dwfs_pkg;

    // Width kept for window coordinates (8..16).
    localparam int COORD_BITS = 16;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_FILL_RECT   = 2'd1,
        OP_DRAW_PIXEL  = 2'd2,
        OP_FILL_SCREEN = 2'd3
    } opcode_t;

    localparam logic [7:0] CMD_COL_SET = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET = 8'h2B;
    localparam logic [7:0] CMD_MEM_WR  = 8'h2C;

    // Header sequence positions.
    localparam logic [3:0] STEP_COL_CMD = 4'd0;
    localparam logic [3:0] STEP_COL_FH  = 4'd1;
    localparam logic [3:0] STEP_COL_FL  = 4'd2;
    localparam logic [3:0] STEP_COL_LH  = 4'd3;
    localparam logic [3:0] STEP_COL_LL  = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD = 4'd5;
    localparam logic [3:0] STEP_ROW_FH  = 4'd6;
    localparam logic [3:0] STEP_ROW_FL  = 4'd7;
    localparam logic [3:0] STEP_ROW_LH  = 4'd8;
    localparam logic [3:0] STEP_ROW_LL  = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD = 4'd10;
    localparam logic [3:0] STEP_PIXELS  = 4'd11;

    localparam int CFG_PANEL_WIDTH  = 0;
    localparam int CFG_PANEL_HEIGHT = 1;

    typedef logic [COORD_BITS-1:0] coord_t;

    // Window decoded from one request.
    typedef struct packed {
        logic        start;
        coord_t      col_first;
        coord_t      col_last;
        coord_t      row_first;
        coord_t      row_last;
        logic [15:0] span_w;
        logic [15:0] span_h;
    } window_t;

endpackage

// File: sv/display_window_fill_sequencer.sv
// Window fill sequencer for a DCS style panel link.
//
// Input stream (s_*): one word per request or tick. s_tuser carries the
// opcode (tick, fill rectangle, draw pixel, fill screen), s_tdata the
// rectangle and color. A request latches a window and emits nothing; each
// following tick word emits one panel byte on the output stream (m_*):
// column set 0x2A + 4 bytes, row set 0x2B + 4 bytes, memory write 0x2C,
// then w*h RGB565 pixels, high byte first. m_tlast marks the final byte.
// Requests while busy, ticks while idle and requests whose start lies
// outside the panel are consumed without output.
//
// Latency: a tick's byte appears in the output register the cycle after the
// tick is accepted. Throughput: one word per cycle while the receiver keeps up;
// the only loop is the set of sequencer state registers. The pixel count w*h is
// formed by one registered multiplier behind the window registers and is
// consumed at the memory write step, well after it settles.
//
// Reset (aresetn low, synchronous): idle, output empty, panel size 240x240.
// When the receiver stalls, the output register holds its byte and
// s_tready drops until it is taken.
module display_window_fill_sequencer
    import dwfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] rect_w, [63:48] rect_h,
    // [79:64] fill_color
    input  logic [79:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    // [0] is_data
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    // Config registers.
    logic [15:0] panel_w_reg;
    logic [15:0] panel_h_reg;

    // Sequencer state.
    logic        busy_reg,     busy_next;
    logic [3:0]  step_reg,     step_next;
    logic        low_half_reg, low_half_next;
    logic [31:0] pixels_reg,   pixels_next;

    // Window payload.
    coord_t      col_first_reg;
    coord_t      col_last_reg;
    coord_t      row_first_reg;
    coord_t      row_last_reg;
    logic [15:0] color_reg;
    logic [15:0] span_w_reg;
    logic [15:0] span_h_reg;
    logic [31:0] product_reg;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg,  m_byte_next;
    logic        m_data_reg,  m_data_next;
    logic        m_last_reg,  m_last_next;

    opcode_t     opcode;
    window_t     win;
    logic        s_fire;
    logic        is_tick;
    logic        load_win;
    logic        emit;
    logic [15:0] col_first_w;
    logic [15:0] col_last_w;
    logic [15:0] row_first_w;
    logic [15:0] row_last_w;

    assign opcode  = opcode_t'(s_tuser);
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign is_tick  = (opcode == OP_TICK);
    assign load_win = s_fire && !is_tick && !busy_reg && win.start;
    assign emit     = s_fire && is_tick && busy_reg;

    assign col_first_w = 16'(col_first_reg);
    assign col_last_w  = 16'(col_last_reg);
    assign row_first_w = 16'(row_first_reg);
    assign row_last_w  = 16'(row_last_reg);

    dwfs_clip u_clip (
        .opcode  (opcode),
        .pos_x   (s_tdata[15:0]),
        .pos_y   (s_tdata[31:16]),
        .rect_w  (s_tdata[47:32]),
        .rect_h  (s_tdata[63:48]),
        .panel_w (panel_w_reg),
        .panel_h (panel_h_reg),
        .win     (win)
    );

    // Window start on a request; byte selection and step advance for one tick.
    always_comb begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        low_half_next = low_half_reg;
        pixels_next   = pixels_reg;
        m_byte_next   = m_byte_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        if (load_win) begin
            busy_next     = 1'b1;
            step_next     = STEP_COL_CMD;
            low_half_next = 1'b0;
        end

        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = 1'b1;
            m_last_next  = 1'b0;
            unique case (step_reg)
                STEP_COL_CMD: begin
                    m_byte_next = CMD_COL_SET;
                    m_data_next = 1'b0;
                end
                STEP_COL_FH: m_byte_next = col_first_w[15:8];
                STEP_COL_FL: m_byte_next = col_first_w[7:0];
                STEP_COL_LH: m_byte_next = col_last_w[15:8];
                STEP_COL_LL: m_byte_next = col_last_w[7:0];
                STEP_ROW_CMD: begin
                    m_byte_next = CMD_ROW_SET;
                    m_data_next = 1'b0;
                end
                STEP_ROW_FH: m_byte_next = row_first_w[15:8];
                STEP_ROW_FL: m_byte_next = row_first_w[7:0];
                STEP_ROW_LH: m_byte_next = row_last_w[15:8];
                STEP_ROW_LL: m_byte_next = row_last_w[7:0];
                STEP_MEM_CMD: begin
                    m_byte_next = CMD_MEM_WR;
                    m_data_next = 1'b0;
                    pixels_next = product_reg;
                    if (product_reg == 32'd0) begin
                        m_last_next = 1'b1;
                    end
                end
                default: begin
                    // pixel phase
                    if (!low_half_reg) begin
                        m_byte_next   = color_reg[15:8];
                        low_half_next = 1'b1;
                    end else begin
                        m_byte_next   = color_reg[7:0];
                        low_half_next = 1'b0;
                        pixels_next   = pixels_reg - 32'd1;
                        if (pixels_reg == 32'd1) begin
                            m_last_next = 1'b1;
                        end
                    end
                end
            endcase

            if (m_last_next) begin
                busy_next = 1'b0;
                step_next = STEP_COL_CMD;
            end else if (step_reg < STEP_PIXELS) begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            panel_w_reg  <= 16'd240;
            panel_h_reg  <= 16'd240;
            busy_reg     <= 1'b0;
            step_reg     <= STEP_COL_CMD;
            low_half_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == 1'(CFG_PANEL_WIDTH)) begin
                    panel_w_reg <= cfg_data;
                end else begin
                    panel_h_reg <= cfg_data;
                end
            end
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            low_half_reg <= low_half_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload, no reset.
    always_ff @(posedge aclk) begin
        if (load_win) begin
            col_first_reg <= win.col_first;
            col_last_reg  <= win.col_last;
            row_first_reg <= win.row_first;
            row_last_reg  <= win.row_last;
            span_w_reg    <= win.span_w;
            span_h_reg    <= win.span_h;
            color_reg     <= s_tdata[79:64];
        end
        // Pixel count settles in the cycle after the window loads.
        product_reg <= span_w_reg * span_h_reg;
        pixels_reg  <= pixels_next;
        m_byte_reg  <= m_byte_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: sv/dwfs_clip.sv
module dwfs_clip
    import dwfs_pkg::*;
(
    input  opcode_t     opcode,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] rect_w,
    input  logic [15:0] rect_h,
    input  logic [15:0] panel_w,
    input  logic [15:0] panel_h,
    output window_t     win
);

    logic [16:0] x_end;
    logic [16:0] y_end;
    logic        clip_x;
    logic        clip_y;
    logic        inside_xy;
    logic [15:0] pw_m1;
    logic [15:0] ph_m1;
    logic [15:0] x_sum_m1;
    logic [15:0] y_sum_m1;
    logic [15:0] w_left;
    logic [15:0] h_left;

    // All adders run in parallel; only comparators and muxes follow.
    assign x_end     = {1'b0, pos_x} + {1'b0, rect_w};
    assign y_end     = {1'b0, pos_y} + {1'b0, rect_h};
    assign clip_x    = x_end > {1'b0, panel_w};
    assign clip_y    = y_end > {1'b0, panel_h};
    assign inside_xy = (pos_x < panel_w) && (pos_y < panel_h);
    assign pw_m1     = panel_w - 16'd1;
    assign ph_m1     = panel_h - 16'd1;
    assign x_sum_m1  = pos_x + rect_w - 16'd1;
    assign y_sum_m1  = pos_y + rect_h - 16'd1;
    assign w_left    = panel_w - pos_x;
    assign h_left    = panel_h - pos_y;

    always_comb begin
        win = '0;
        unique case (opcode)
            OP_FILL_SCREEN: begin
                win.start     = 1'b1;
                win.col_first = '0;
                win.row_first = '0;
                win.col_last  = COORD_BITS'(pw_m1);
                win.row_last  = COORD_BITS'(ph_m1);
                win.span_w    = panel_w;
                win.span_h    = panel_h;
            end
            OP_DRAW_PIXEL: begin
                win.start     = inside_xy;
                win.col_first = COORD_BITS'(pos_x);
                win.row_first = COORD_BITS'(pos_y);
                win.col_last  = COORD_BITS'(pos_x);
                win.row_last  = COORD_BITS'(pos_y);
                win.span_w    = 16'd1;
                win.span_h    = 16'd1;
            end
            OP_FILL_RECT: begin
                win.start     = inside_xy;
                win.col_first = COORD_BITS'(pos_x);
                win.row_first = COORD_BITS'(pos_y);
                win.col_last  = COORD_BITS'(clip_x ? pw_m1 : x_sum_m1);
                win.row_last  = COORD_BITS'(clip_y ? ph_m1 : y_sum_m1);
                win.span_w    = clip_x ? w_left : rect_w;
                win.span_h    = clip_y ? h_left : rect_h;
            end
            default: begin
                win = '0;   // tick
            end
        endcase
    end

endmodule

// File: bench/tb_display_window_fill_sequencer.sv
module tb_display_window_fill_sequencer
    import dwfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Largest window the random part asks for. It keeps the pixel bursts short,
    // so the run is spent mostly on headers, clipping and request handling.
    localparam int MAX_PIX      = 24;
    // Idle cycles allowed after the last byte before a register write, and at the end.
    localparam int SETTLE_CYCLES = 6;
    // Far above the slowest correct run: about 1600 words under the heaviest
    // idling, plus the drains between settings.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PRINT_CAP    = 100;

    // One word on the request stream.
    typedef struct {
        opcode_t     op;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] color;
        bit          drain;     // hold the word back until every byte has come out
    } fill_word_t;

    // One byte on the panel stream.
    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       last;
    } panel_byte_t;

    // ------------------------------------------------------------------
    // DUT hookup. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;   // x, y, w, h, color from bit 0 up
    logic [1:0]  s_tuser   = '0;   // opcode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // panel byte
    logic [0:0]  m_tuser;          // is_data
    logic        m_tlast;

    display_window_fill_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    fill_word_t  request_queue[$];     // words still to be driven
    panel_byte_t expected_bytes[$];    // predicted panel bytes, oldest first
    int unsigned words_in       = 0;   // words accepted so far
    int unsigned useful_words   = 0;   // ticks and window starts queued
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic        word_taken     = 1'b0; // the word on the bus went in at the last edge

    // Panel size as the stimulus side sees it (changed only while idle).
    logic [15:0] gen_panel_w = 16'd240;
    logic [15:0] gen_panel_h = 16'd240;

    // Predictor copy of the block: panel size and sequencer state.
    logic [15:0] panel_w       = 16'd240;
    logic [15:0] panel_h       = 16'd240;
    logic        seq_busy      = 1'b0;
    logic [3:0]  seq_step      = STEP_COL_CMD;
    logic [15:0] win_col_first = '0;
    logic [15:0] win_col_last  = '0;
    logic [15:0] win_row_first = '0;
    logic [15:0] win_row_last  = '0;
    logic [15:0] win_color     = '0;
    logic [31:0] pixels_left   = '0;
    logic        low_byte_next = 1'b0;

    // ------------------------------------------------------------------
    // Window decode, used by the predictor and by the stimulus to size the
    // tick run. Returns 1 when the request would open a window on an idle block.
    // Rectangles are clipped at the panel edge; a zero size makes the end
    // coordinate wrap below the start and gives zero pixels.
    // ------------------------------------------------------------------
    function automatic logic plan_window(input opcode_t op, input logic [15:0] x, y, w, h,
                                         input logic [15:0] pw, ph,
                                         output logic [15:0] x0, y0, x1, y1,
                                         output logic [31:0] pixels);
        logic [31:0] span_w;
        logic [31:0] span_h;
        x0 = '0; y0 = '0; x1 = '0; y1 = '0; pixels = '0;
        if (op == OP_FILL_SCREEN) begin
            x1 = pw - 16'd1;
            y1 = ph - 16'd1;
            pixels = 32'(pw) * 32'(ph);
            return 1'b1;
        end
        if (op == OP_TICK || x >= pw || y >= ph)
            return 1'b0;
        x0 = x;
        y0 = y;
        if (op == OP_DRAW_PIXEL) begin
            x1 = x;
            y1 = y;
            pixels = 32'd1;
            return 1'b1;
        end
        span_w = (32'(x) + 32'(w) > 32'(pw)) ? 32'(pw - x) : 32'(w);
        span_h = (32'(y) + 32'(h) > 32'(ph)) ? 32'(ph - y) : 32'(h);
        x1 = 16'(32'(x) + span_w - 32'd1);
        y1 = 16'(32'(y) + span_h - 32'd1);
        pixels = span_w * span_h;
        return 1'b1;
    endfunction

    // Advance the predicted sequencer by one accepted word; a tick on a busy
    // block yields exactly one panel byte.
    task automatic step_sequencer(input fill_word_t wd);
        logic [15:0] x0, y0, x1, y1;
        logic [31:0] n;
        panel_byte_t b;
        if (wd.op != OP_TICK) begin
            // requests on a busy block are swallowed
            if (!seq_busy && plan_window(wd.op, wd.x, wd.y, wd.w, wd.h, panel_w, panel_h,
                                         x0, y0, x1, y1, n)) begin
                seq_busy      = 1'b1;
                seq_step      = STEP_COL_CMD;
                win_col_first = x0;
                win_row_first = y0;
                win_col_last  = x1;
                win_row_last  = y1;
                pixels_left   = n;
                win_color     = wd.color;
                low_byte_next = 1'b0;
            end
            return;
        end
        if (!seq_busy)
            return;
        b.is_data = 1'b1;
        b.last    = 1'b0;
        case (seq_step)
            STEP_COL_CMD: begin
                b.value   = CMD_COL_SET;
                b.is_data = 1'b0;
            end
            STEP_COL_FH:  b.value = win_col_first[15:8];
            STEP_COL_FL:  b.value = win_col_first[7:0];
            STEP_COL_LH:  b.value = win_col_last[15:8];
            STEP_COL_LL:  b.value = win_col_last[7:0];
            STEP_ROW_CMD: begin
                b.value   = CMD_ROW_SET;
                b.is_data = 1'b0;
            end
            STEP_ROW_FH:  b.value = win_row_first[15:8];
            STEP_ROW_FL:  b.value = win_row_first[7:0];
            STEP_ROW_LH:  b.value = win_row_last[15:8];
            STEP_ROW_LL:  b.value = win_row_last[7:0];
            STEP_MEM_CMD: begin
                b.value   = CMD_MEM_WR;
                b.is_data = 1'b0;
                // empty window: the memory write command closes the request
                if (pixels_left == 0) begin
                    b.last   = 1'b1;
                    seq_busy = 1'b0;
                end
            end
            default: begin
                // pixel phase, RGB565 high byte first
                if (!low_byte_next) begin
                    b.value       = win_color[15:8];
                    low_byte_next = 1'b1;
                end else begin
                    b.value       = win_color[7:0];
                    low_byte_next = 1'b0;
                    pixels_left   = pixels_left - 32'd1;
                    if (pixels_left == 0) begin
                        b.last   = 1'b1;
                        seq_busy = 1'b0;
                    end
                end
            end
        endcase
        if (seq_step < STEP_PIXELS)
            seq_step = seq_step + 4'd1;
        if (!seq_busy)
            seq_step = STEP_COL_CMD;
        expected_bytes.push_back(b);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Idling regimes, keyed on progress: sender 36% / receiver 50%, then
    // swapped, then a last stretch running flat out on both sides.
    // ------------------------------------------------------------------
    function automatic int send_idle_pct();
        return (words_in < 520) ? 36 : (words_in < 1040) ? 50 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (words_in < 520) ? 50 : (words_in < 1040) ? 36 : 0;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: works the pending queue at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_words
        fill_word_t nw;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !word_taken) begin
            // still waiting for the handshake, hold the word
        end else if (request_queue.size() == 0 ||
                     (request_queue[0].drain && expected_bytes.size() != 0) ||
                     $urandom_range(99) < send_idle_pct()) begin
            s_tvalid <= 1'b0;
        end else begin
            nw = request_queue.pop_front();
            s_tdata  <= {nw.color, nw.h, nw.w, nw.y, nw.x};
            s_tuser  <= nw.op;
            s_tvalid <= 1'b1;
        end
    end

    // Panel-side back pressure.
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct());
    end

    // ------------------------------------------------------------------
    // Monitor and predictor. Outputs are checked before the word accepted at
    // this edge is predicted: its byte only enters the output register at this edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_and_predict
        fill_word_t  got;
        panel_byte_t want;
        if (!aresetn) begin
            panel_w       = 16'd240;
            panel_h       = 16'd240;
            seq_busy      = 1'b0;
            seq_step      = STEP_COL_CMD;
            pixels_left   = '0;
            low_byte_next = 1'b0;
            expected_bytes.delete();
            word_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h is_data %0b last %0b",
                                              m_tdata, m_tuser[0], m_tlast));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_tdata, want.value));
                    if (m_tuser[0] !== want.is_data)
                        report_mismatch($sformatf("is_data %0b, expected %0b (byte %02h)",
                                                  m_tuser[0], want.is_data, want.value));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                                  m_tlast, want.last, want.value));
                end
            end
            if (cfg_we) begin
                if (cfg_index == 1'(CFG_PANEL_WIDTH))
                    panel_w = cfg_data;
                else if (cfg_index == 1'(CFG_PANEL_HEIGHT))
                    panel_h = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                got.op    = opcode_t'(s_tuser);
                got.x     = s_tdata[15:0];
                got.y     = s_tdata[31:16];
                got.w     = s_tdata[47:32];
                got.h     = s_tdata[63:48];
                got.color = s_tdata[79:64];
                got.drain = 1'b0;
                step_sequencer(got);
                words_in++;
            end
            word_taken <= s_tvalid && s_tready;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input opcode_t op, input logic [15:0] x, y, w, h, color,
                             input bit drain);
        fill_word_t nw;
        nw.op = op; nw.x = x; nw.y = y; nw.w = w; nw.h = h;
        nw.color = color; nw.drain = drain;
        request_queue.push_back(nw);
    endtask

    // Queue a request on an idle block, followed by exactly the ticks that
    // drain it. intrude_at >= 0 slips a stray request in before that tick;
    // the block is still busy then and must swallow it.
    task automatic queue_fill(input opcode_t op, input logic [15:0] x, y, w, h, color,
                              input bit drain, input int intrude_at);
        logic [15:0] x0, y0, x1, y1;
        logic [31:0] n;
        int          total;
        push_word(op, x, y, w, h, color, drain);
        if (!plan_window(op, x, y, w, h, gen_panel_w, gen_panel_h, x0, y0, x1, y1, n))
            return;
        total = int'(STEP_PIXELS) + 2 * int'(n);
        useful_words += 1 + total;
        for (int i = 0; i < total; i++) begin
            if (i == intrude_at)
                push_word(opcode_t'($urandom_range(3, 1)), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
            push_word(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 1'b0);
        end
    endtask

    // Start coordinate inside a panel extent, biased to the edges.
    function automatic logic [15:0] pick_coord(input logic [15:0] extent);
        int unsigned r;
        r = $urandom_range(3);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return extent - 16'd1 - 16'($urandom_range((extent > 16'd4) ? 3 : extent - 1));
        return 16'($urandom_range(extent - 1));
    endfunction

    // Size: zero, anything at all (clipped), or small.
    function automatic logic [15:0] pick_size();
        int unsigned r;
        r = $urandom_range(3);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(6, 1));
    endfunction

    // Mostly complete request+tick runs with random windows, plus noise:
    // ticks on an idle block and requests that start off the panel.
    task automatic random_phase(input int unsigned n_words);
        int unsigned stop;
        int unsigned r;
        opcode_t     op;
        logic [15:0] x, y, w, h;
        logic [15:0] x0, y0, x1, y1;
        logic [31:0] n;
        int          intrude;
        stop = useful_words + n_words;
        while (useful_words < stop) begin
            r = $urandom_range(99);
            if (r < 6) begin
                queue_fill(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 1'b0, -1);
            end else if (r < 14) begin
                op = $urandom_range(1) ? OP_FILL_RECT : OP_DRAW_PIXEL;
                if ($urandom_range(1)) begin
                    x = 16'($urandom_range(65535, gen_panel_w));
                    y = 16'($urandom);
                end else begin
                    x = 16'($urandom);
                    y = 16'($urandom_range(65535, gen_panel_h));
                end
                queue_fill(op, x, y, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, -1);
            end else begin
                r = $urandom_range(99);
                if (r < 10 && 32'(gen_panel_w) * 32'(gen_panel_h) <= MAX_PIX)
                    op = OP_FILL_SCREEN;
                else if (r < 35)
                    op = OP_DRAW_PIXEL;
                else
                    op = OP_FILL_RECT;
                // redraw until the window is short enough
                do begin
                    x = pick_coord(gen_panel_w);
                    y = pick_coord(gen_panel_h);
                    w = pick_size();
                    h = pick_size();
                    void'(plan_window(op, x, y, w, h, gen_panel_w, gen_panel_h,
                                      x0, y0, x1, y1, n));
                end while (n > MAX_PIX);
                intrude = ($urandom_range(9) == 0) ?
                          int'($urandom_range(int'(STEP_PIXELS) + 2 * int'(n) - 1)) : -1;
                queue_fill(op, x, y, w, h, 16'($urandom), $urandom_range(29) == 0, intrude);
            end
        end
    endtask

    // Block until everything queued has gone in and every byte has come out,
    // then let anything still in flight settle.
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (request_queue.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input int idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= 1'(idx);
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_panel(input logic [15:0] pw, ph);
        write_reg(CFG_PANEL_WIDTH, pw);
        write_reg(CFG_PANEL_HEIGHT, ph);
        gen_panel_w = pw;
        gen_panel_h = ph;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        // panel sizes per setting: tiny, single pixel, maximum, thin strips,
        // then a random mid-size panel
        logic [15:0] setting_w[6];
        logic [15:0] setting_h[6];
        setting_w = '{16'd3, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0};
        setting_h = '{16'd2, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0};
        setting_w[5] = 16'($urandom_range(400, 1));
        setting_h[5] = 16'($urandom_range(400, 1));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, on the 240x240 reset size.
        // tick with nothing to send
        queue_fill(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, -1);
        // single pixel in the bottom-right corner
        queue_fill(OP_DRAW_PIXEL, 16'd239, 16'd239, 16'd0, 16'd0, 16'hFFFF, 1'b0, -1);
        // oversized rectangle clipped to 2x1 at the corner
        queue_fill(OP_FILL_RECT, 16'd238, 16'd239, 16'hFFFF, 16'hFFFF, 16'h5AA5, 1'b0, -1);
        // zero size: end coordinates wrap to FFFF, memory write carries last
        queue_fill(OP_FILL_RECT, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 1'b0, -1);
        // starts just off the panel in x, then in y: dropped
        queue_fill(OP_FILL_RECT, 16'd240, 16'd0, 16'd1, 16'd1, 16'h1111, 1'b0, -1);
        queue_fill(OP_DRAW_PIXEL, 16'd0, 16'd240, 16'd1, 16'd1, 16'h2222, 1'b0, -1);
        // held back until the panel stream is empty; a stray request mid-header
        queue_fill(OP_FILL_RECT, 16'd5, 16'd7, 16'd1, 16'd2, 16'h1234, 1'b1, 3);
        random_phase(200);

        foreach (setting_w[i]) begin
            wait_idle();
            set_panel(setting_w[i], setting_h[i]);
            if (i == 0)
                // whole screen on a 3x2 panel
                queue_fill(OP_FILL_SCREEN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'hC0DE, 1'b0, -1);
            if (i == 2)
                // clipping at the far corner of the largest panel
                queue_fill(OP_FILL_RECT, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'd2,
                           16'h8001, 1'b0, -1);
            random_phase(200);
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
